[hdl/itra_pkg.sv]
// ----------------------------------------------------------------------------
// itra_pkg: shared types and constants for the radix ascii converter
// Character codes, configuration register indexes, controller command and
// status bundles, and the digit to character mapping.
// ----------------------------------------------------------------------------
package itra_pkg;

    // default operand width
    localparam int VALUE_WIDTH_DEF = 32;

    // radix register and its usable range
    localparam int RADIX_W = 6;
    localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
    localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;

    // quotient bits resolved per divider cycle
    localparam int DIV_STEP_BITS = 4;

    // configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 8;
    localparam logic [CFG_INDEX_W-1:0] CFG_RADIX      = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_UPPER_CASE = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_COMPLEMENT = 2'd2;

    // character codes
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_TILDE   = 8'h7E;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] DIGIT_TEN  = 8'd10;

    // source of a character written to the digit store
    typedef enum logic [2:0] {
        PUSH_DIGIT = 3'd0,
        PUSH_CMAX  = 3'd1,
        PUSH_MINUS = 3'd2,
        PUSH_TILDE = 3'd3,
        PUSH_ZERO  = 3'd4
    } push_sel_t;

    // controller to datapath commands
    typedef struct packed {
        logic      load;
        logic      div_start;
        logic      push;
        push_sel_t push_sel;
        logic      quot_take;
        logic      rd_issue;
        logic      out_load;
        logic      cnt_dec;
    } itra_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic quot_zero;
        logic div_done;
        logic cneg;
        logic neg;
        logic count_zero;
        logic count_one;
        logic out_taken;
    } itra_status_t;

    // digit value to ascii character
    function automatic logic [7:0] digit_char(input logic [RADIX_W-1:0] d,
                                              input logic upper);
        logic [7:0] d8;
        logic [7:0] base;
        d8   = {2'b00, d};
        base = upper ? CH_UPPER_A : CH_LOWER_A;
        if (d8 < DIGIT_TEN) begin
            return CH_ZERO + d8;
        end
        return base + d8 - DIGIT_TEN;
    endfunction

endpackage

[hdl/itra_divider.sv]
// ----------------------------------------------------------------------------
// itra_divider: iterative division by a small radix
// Restoring division that resolves DIV_STEP_BITS quotient bits per cycle and
// pulses done as the result of the last step is registered.
// ----------------------------------------------------------------------------
module itra_divider #(
    parameter int VALUE_WIDTH = itra_pkg::VALUE_WIDTH_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [VALUE_WIDTH-1:0]      dividend,
    input  logic [itra_pkg::RADIX_W-1:0] divisor,
    output logic                        done,
    output logic [VALUE_WIDTH-1:0]      quotient,
    output logic [itra_pkg::RADIX_W-1:0] remainder
);

    localparam int STEP_BITS  = itra_pkg::DIV_STEP_BITS;
    localparam int STEPS      = (VALUE_WIDTH + STEP_BITS - 1) / STEP_BITS;
    localparam int SH_W       = STEPS * STEP_BITS;
    localparam int STEP_CNT_W = $clog2(STEPS);
    localparam int RW         = itra_pkg::RADIX_W;

    logic [SH_W-1:0]       sh_reg;
    logic [SH_W-1:0]       sh_next;
    logic [RW-1:0]         rem_reg;
    logic [RW-1:0]         rem_next;
    logic [RW:0]           trial;
    logic [STEP_CNT_W-1:0] step_reg;
    logic                  busy_reg;
    logic                  done_reg;

    // one step of compare and subtract, DIV_STEP_BITS bits deep
    always_comb begin
        sh_next  = sh_reg;
        rem_next = rem_reg;
        trial    = '0;
        for (int i = 0; i < STEP_BITS; i++) begin
            trial   = {rem_next, sh_next[SH_W-1]};
            sh_next = {sh_next[SH_W-2:0], 1'b0};
            if (trial >= {1'b0, divisor}) begin
                trial      = trial - {1'b0, divisor};
                sh_next[0] = 1'b1;
            end
            rem_next = trial[RW-1:0];
        end
    end

    // step counter and handshake flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end else if (busy_reg) begin
                if (step_reg == STEP_CNT_W'(STEPS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    step_reg <= step_reg + 1'b1;
                end
            end
        end
    end

    // shift register: dividend leaves at the top, quotient enters at the bottom
    always_ff @(posedge aclk) begin
        if (start) begin
            sh_reg  <= SH_W'(dividend);
            rem_reg <= '0;
        end else if (busy_reg) begin
            sh_reg  <= sh_next;
            rem_reg <= rem_next;
        end
    end

    assign done      = done_reg;
    assign quotient  = sh_reg[VALUE_WIDTH-1:0];
    assign remainder = rem_reg;

endmodule

[hdl/itra_datapath.sv]
// ----------------------------------------------------------------------------
// itra_datapath: registers, divider, digit store and output beat register
// Holds configuration, the running quotient and the characters in reverse
// order, and replays them most significant first under controller command.
// ----------------------------------------------------------------------------
module itra_datapath #(
    parameter int VALUE_WIDTH = itra_pkg::VALUE_WIDTH_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic signed [VALUE_WIDTH-1:0]       s_value,
    input  logic                                cfg_valid,
    input  logic [itra_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [itra_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                m_ready,
    input  itra_pkg::itra_cmd_t                 cmd,
    output itra_pkg::itra_status_t              status,
    output logic                                m_valid,
    output logic [7:0]                          m_char_code,
    output logic                                m_last
);

    localparam int RW     = itra_pkg::RADIX_W;
    localparam int DEPTH  = VALUE_WIDTH + 1;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    logic [RW-1:0]          radix_reg;
    logic                   upper_reg;
    logic                   comp_reg;
    logic [RW-1:0]          radix_eff;
    logic [RW-1:0]          cmax;
    logic [VALUE_WIDTH-1:0] raw;
    logic [VALUE_WIDTH-1:0] quot_reg;
    logic [VALUE_WIDTH-1:0] quot_init;
    logic                   neg_reg;
    logic                   cneg_reg;
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_m1;
    logic [7:0]             digit_mem [DEPTH];
    logic [7:0]             rd_data_reg;
    logic [7:0]             push_char;
    logic                   div_done;
    logic [VALUE_WIDTH-1:0] div_quot;
    logic [RW-1:0]          div_rem;
    logic                   m_valid_reg;
    logic [7:0]             m_char_reg;
    logic                   m_last_reg;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radix_reg <= itra_pkg::RADIX_RESET;
            upper_reg <= 1'b0;
            comp_reg  <= 1'b0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                itra_pkg::CFG_RADIX:      radix_reg <= cfg_data[RW-1:0];
                itra_pkg::CFG_UPPER_CASE: upper_reg <= cfg_data[0];
                itra_pkg::CFG_COMPLEMENT: comp_reg  <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // radix clamped to the usable range
    always_comb begin
        if (radix_reg < itra_pkg::RADIX_MIN) begin
            radix_eff = itra_pkg::RADIX_MIN;
        end else if (radix_reg > itra_pkg::RADIX_MAX) begin
            radix_eff = itra_pkg::RADIX_MAX;
        end else begin
            radix_eff = radix_reg;
        end
    end
    assign cmax = radix_eff - 1'b1;

    // starting quotient: inverse of a negative value in complement mode, magnitude otherwise
    assign raw = s_value;
    always_comb begin
        if (raw[VALUE_WIDTH-1] && comp_reg) begin
            quot_init = ~raw;
        end else if (raw[VALUE_WIDTH-1]) begin
            quot_init = ~raw + VALUE_WIDTH'(1);
        end else begin
            quot_init = raw;
        end
    end

    // running quotient and sign flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            quot_reg <= '0;
            neg_reg  <= 1'b0;
            cneg_reg <= 1'b0;
        end else if (cmd.load) begin
            quot_reg <= quot_init;
            neg_reg  <= raw[VALUE_WIDTH-1];
            cneg_reg <= raw[VALUE_WIDTH-1] & comp_reg;
        end else if (cmd.quot_take) begin
            quot_reg <= div_quot;
        end
    end

    itra_divider #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.div_start),
        .dividend  (quot_reg),
        .divisor   (radix_eff),
        .done      (div_done),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    // character selection for the digit store
    always_comb begin
        unique case (cmd.push_sel)
            itra_pkg::PUSH_DIGIT: begin
                push_char = itra_pkg::digit_char(cneg_reg ? cmax - div_rem : div_rem,
                                                 upper_reg);
            end
            itra_pkg::PUSH_CMAX:  push_char = itra_pkg::digit_char(cmax, upper_reg);
            itra_pkg::PUSH_MINUS: push_char = itra_pkg::CH_MINUS;
            itra_pkg::PUSH_TILDE: push_char = itra_pkg::CH_TILDE;
            itra_pkg::PUSH_ZERO:  push_char = itra_pkg::CH_ZERO;
            default:              push_char = itra_pkg::CH_ZERO;
        endcase
    end

    // character count: grows on push, shrinks as beats leave
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (cmd.load) begin
            count_reg <= '0;
        end else if (cmd.push) begin
            count_reg <= count_reg + 1'b1;
        end else if (cmd.cnt_dec) begin
            count_reg <= count_reg - 1'b1;
        end
    end
    assign count_m1 = count_reg - CNT_W'(1);

    // digit store, one write and one registered read port
    always_ff @(posedge aclk) begin
        if (cmd.push) begin
            digit_mem[count_reg[IDX_W-1:0]] <= push_char;
        end
        if (cmd.rd_issue) begin
            rd_data_reg <= digit_mem[count_m1[IDX_W-1:0]];
        end
    end

    // output beat register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_char_reg <= rd_data_reg;
            m_last_reg <= (count_reg == CNT_W'(1));
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_char_code = m_char_reg;
    assign m_last      = m_last_reg;

    // status back to the controller
    assign status.quot_zero  = (quot_reg == '0);
    assign status.div_done   = div_done;
    assign status.cneg       = cneg_reg;
    assign status.neg        = neg_reg;
    assign status.count_zero = (count_reg == '0);
    assign status.count_one  = (count_reg == CNT_W'(1));
    assign status.out_taken  = m_valid_reg & m_ready;

endmodule

[hdl/itra_ctrl.sv]
// ----------------------------------------------------------------------------
// itra_ctrl: sequencing state machine
// Runs one division per digit until the quotient is zero, appends the sign
// characters, then replays the stored characters one beat at a time.
// ----------------------------------------------------------------------------
module itra_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  itra_pkg::itra_status_t status,
    output itra_pkg::itra_cmd_t    cmd
);

    typedef enum logic [6:0] {
        ST_IDLE      = 7'b0000001,
        ST_DIV_CHECK = 7'b0000010,
        ST_DIV_RUN   = 7'b0000100,
        ST_TAIL      = 7'b0001000,
        ST_EMIT_RD   = 7'b0010000,
        ST_EMIT_LD   = 7'b0100000,
        ST_EMIT_WAIT = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state and command decode
    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        cmd.push_sel = itra_pkg::PUSH_DIGIT;
        s_ready      = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_DIV_CHECK;
                end
            end
            ST_DIV_CHECK: begin
                if (!status.quot_zero) begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV_RUN;
                end else if (status.cneg) begin
                    // leading digit of radix minus one, tilde follows
                    cmd.push     = 1'b1;
                    cmd.push_sel = itra_pkg::PUSH_CMAX;
                    state_next   = ST_TAIL;
                end else if (status.neg) begin
                    cmd.push     = 1'b1;
                    cmd.push_sel = itra_pkg::PUSH_MINUS;
                    state_next   = ST_EMIT_RD;
                end else if (status.count_zero) begin
                    // a zero input has no digits of its own
                    cmd.push     = 1'b1;
                    cmd.push_sel = itra_pkg::PUSH_ZERO;
                    state_next   = ST_EMIT_RD;
                end else begin
                    state_next = ST_EMIT_RD;
                end
            end
            ST_DIV_RUN: begin
                if (status.div_done) begin
                    cmd.push      = 1'b1;
                    cmd.push_sel  = itra_pkg::PUSH_DIGIT;
                    cmd.quot_take = 1'b1;
                    state_next    = ST_DIV_CHECK;
                end
            end
            ST_TAIL: begin
                cmd.push     = 1'b1;
                cmd.push_sel = itra_pkg::PUSH_TILDE;
                state_next   = ST_EMIT_RD;
            end
            ST_EMIT_RD: begin
                cmd.rd_issue = 1'b1;
                state_next   = ST_EMIT_LD;
            end
            ST_EMIT_LD: begin
                cmd.out_load = 1'b1;
                state_next   = ST_EMIT_WAIT;
            end
            ST_EMIT_WAIT: begin
                if (status.out_taken) begin
                    cmd.cnt_dec = 1'b1;
                    state_next  = status.count_one ? ST_IDLE : ST_EMIT_RD;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[hdl/int_to_radix_ascii.sv]
// ----------------------------------------------------------------------------
// int_to_radix_ascii: signed integer to ascii text in radix 2 to 36
// Each digit takes one pass of the shared divider loop, and each character then
//   goes out through the read, load and wait states, held by any output stall.
// One number at a time: a new number is taken only once all its text is out.
// Reset: synchronous active low; radix 10, lower case, complement mode off.
// ----------------------------------------------------------------------------
module int_to_radix_ascii #(
    parameter int VALUE_WIDTH = itra_pkg::VALUE_WIDTH_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic signed [VALUE_WIDTH-1:0]    s_value,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [7:0]                       m_char_code,
    output logic                             m_last,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [itra_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [itra_pkg::CFG_DATA_W-1:0]  cfg_data
);

    itra_pkg::itra_cmd_t    cmd;
    itra_pkg::itra_status_t status;

    // configuration writes are always accepted
    assign cfg_ready = 1'b1;

    itra_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    itra_datapath #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_value     (s_value),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .m_ready     (m_ready),
        .cmd         (cmd),
        .status      (status),
        .m_valid     (m_valid),
        .m_char_code (m_char_code),
        .m_last      (m_last)
    );

endmodule

[hdl/itra_checker.sv]
// ----------------------------------------------------------------------------
// itra_checker: port level checks for the radix ascii converter
// Watches the input and result channels and is bound to the top level.
// ----------------------------------------------------------------------------
module itra_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_char_code,
    input logic       m_last
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_char_code) && $stable(m_last))
        else $error("result beat changed while stalled");

    // no new number is taken while characters are still going out
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input ready while a result beat is pending");

    // an accepted number closes the input until its text is done
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input ready straight after an accept");

    // nothing follows the final character of a number
    a_quiet_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_last |=> !m_valid)
        else $error("result beat straight after the final character");

endmodule

bind int_to_radix_ascii itra_checker u_itra_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_char_code (m_char_code),
    .m_last      (m_last)
);

[dv/tb_int_to_radix_ascii.sv]
// ----------------------------------------------------------------------------
// tb_int_to_radix_ascii: self-checking bench for the radix ascii converter
// Numbers go in on the s_ channel and their expected text is worked out at
// the accepting beat. Characters coming out on the m_ channel are checked
// in order against that text. A directed set covers zero, the extremes, sign
// and tilde forms and saturated radix, then random phases with random register
// settings follow. Both sides stall at random.
// ----------------------------------------------------------------------------
module tb_int_to_radix_ascii;

    localparam int WIDTH          = 32;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = 40;
    localparam int PHASE_ITEMS    = 25;
    localparam logic [itra_pkg::CFG_INDEX_W-1:0] CFG_SPARE = 2'd3;

    logic                                aclk      = 1'b0;
    logic                                aresetn   = 1'b0;
    logic                                s_valid   = 1'b0;
    logic                                s_ready;
    logic signed [WIDTH-1:0]             s_value   = '0;
    logic                                m_valid;
    logic                                m_ready   = 1'b0;
    logic [7:0]                          m_char_code;
    logic                                m_last;
    logic                                cfg_valid = 1'b0;
    logic                                cfg_ready;
    logic [itra_pkg::CFG_INDEX_W-1:0]    cfg_index = '0;
    logic [itra_pkg::CFG_DATA_W-1:0]     cfg_data  = '0;

    // register image kept in step with the block
    logic [itra_pkg::RADIX_W-1:0] radix_reg = itra_pkg::RADIX_RESET;
    logic                         upper_reg = 1'b0;
    logic                         comp_reg  = 1'b0;

    logic [WIDTH-1:0] pending_values[$];
    logic [7:0]       text_chars_due[$];
    logic             text_last_due[$];
    int               values_queued = 0;
    int               values_taken  = 0;
    int               send_gap      = 0;
    int               recv_hold     = 0;
    int               idle_cycles   = 0;
    int               errors        = 0;
    logic             calm          = 1'b0;

    int_to_radix_ascii #(.VALUE_WIDTH(WIDTH)) dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_value     (s_value),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_char_code (m_char_code),
        .m_last      (m_last),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm) return 0;
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    // one digit value to its character, letter case from the register image
    function automatic logic [7:0] digit_ascii(input logic [itra_pkg::RADIX_W-1:0] d);
        logic [7:0] wide;
        wide = {2'b00, d};
        if (wide < itra_pkg::DIGIT_TEN) return itra_pkg::CH_ZERO + wide;
        return (upper_reg ? itra_pkg::CH_UPPER_A : itra_pkg::CH_LOWER_A) + wide
               - itra_pkg::DIGIT_TEN;
    endfunction

    // text of one number, appended to the characters due
    function automatic void predict_text(input logic [WIDTH-1:0] raw);
        logic [7:0]                   rev[$];
        logic [WIDTH-1:0]             quo;
        logic [itra_pkg::RADIX_W-1:0] base;
        logic [itra_pkg::RADIX_W-1:0] rem;
        base = (radix_reg < itra_pkg::RADIX_MIN) ? itra_pkg::RADIX_MIN :
               (radix_reg > itra_pkg::RADIX_MAX) ? itra_pkg::RADIX_MAX : radix_reg;
        if (raw[WIDTH-1] && comp_reg) begin
            // tilde form: complemented digits of the inverse, then a top digit
            quo = ~raw;
            while (quo != 0) begin
                rem = itra_pkg::RADIX_W'(quo % base);
                quo = quo / base;
                rev.push_back(digit_ascii(base - 6'd1 - rem));
            end
            rev.push_back(digit_ascii(base - 6'd1));
            rev.push_back(itra_pkg::CH_TILDE);
        end else if (raw == 0) begin
            rev.push_back(itra_pkg::CH_ZERO);
        end else begin
            // magnitude as unsigned, so the most negative value is fine
            quo = raw[WIDTH-1] ? -raw : raw;
            while (quo != 0) begin
                rem = itra_pkg::RADIX_W'(quo % base);
                quo = quo / base;
                rev.push_back(digit_ascii(rem));
            end
            if (raw[WIDTH-1]) rev.push_back(itra_pkg::CH_MINUS);
        end
        for (int k = rev.size() - 1; k >= 0; k--) begin
            text_chars_due.push_back(rev[k]);
            text_last_due.push_back(k == 0);
        end
    endfunction

    // number driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid  <= 1'b0;
            send_gap <= 0;
        end else begin
            if (s_valid && s_ready) begin
                predict_text(s_value);
                values_taken++;
            end
            if (!s_valid || s_ready) begin
                if (send_gap > 0) begin
                    s_valid  <= 1'b0;
                    send_gap <= send_gap - 1;
                end else if (pending_values.size() > 0) begin
                    s_valid  <= 1'b1;
                    s_value  <= pending_values.pop_front();
                    send_gap <= pick_gap();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // character monitor with random back-pressure
    always @(posedge aclk) begin : char_check
        logic [7:0] want_char;
        logic       want_last;
        if (!aresetn) begin
            m_ready   <= 1'b0;
            recv_hold <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (text_chars_due.size() == 0) begin
                    $error("unexpected character beat: char_code %h last %b",
                           m_char_code, m_last);
                    errors++;
                end else begin
                    want_char = text_chars_due.pop_front();
                    want_last = text_last_due.pop_front();
                    if (m_char_code !== want_char) begin
                        $error("char_code: expected %h, got %h", want_char, m_char_code);
                        errors++;
                    end
                    if (m_last !== want_last) begin
                        $error("last: expected %b, got %b", want_last, m_last);
                        errors++;
                    end
                end
            end
            if (recv_hold > 0) begin
                m_ready   <= 1'b0;
                recv_hold <= recv_hold - 1;
            end else begin
                m_ready <= 1'b1;
                if ($urandom_range(0, 3) == 0) recv_hold <= pick_gap();
            end
        end
    end

    // watchdog on cycles with no beat on any channel
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("int_to_radix_ascii: mismatch");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic queue_value(input logic [WIDTH-1:0] v);
        pending_values.push_back(v);
        values_queued++;
    endtask

    // one register write, then the channel is left quiet before the task returns
    task automatic write_reg(input logic [itra_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [itra_pkg::CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        case (idx)
            itra_pkg::CFG_RADIX:      radix_reg = data[itra_pkg::RADIX_W-1:0];
            itra_pkg::CFG_UPPER_CASE: upper_reg = data[0];
            itra_pkg::CFG_COMPLEMENT: comp_reg  = data[0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    // wait until every number is taken and all its text has come out
    task automatic wait_drained();
        while (values_taken != values_queued || text_chars_due.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    initial begin : stimulus
        logic [WIDTH-1:0]                v;
        logic [itra_pkg::CFG_DATA_W-1:0] rdata;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: decimal, sign form
        queue_value(32'd0);
        queue_value(32'd1);
        queue_value(-32'sd1);
        queue_value(32'd9);
        queue_value(32'd10);
        queue_value(-32'sd10);
        queue_value(32'h7fff_ffff);
        queue_value(32'h8000_0000);
        queue_value(32'd1234567890);
        wait_drained();

        // radix 36, capitals, tilde form; junk in the unused data bits
        write_reg(itra_pkg::CFG_RADIX, 8'he4);
        write_reg(itra_pkg::CFG_UPPER_CASE, 8'hff);
        write_reg(itra_pkg::CFG_COMPLEMENT, 8'h03);
        queue_value(-32'sd1);
        queue_value(32'h8000_0000);
        queue_value(-32'sd36);
        queue_value(-32'sd37);
        queue_value(32'd35);
        queue_value(32'h7fff_ffff);
        queue_value(32'd0);
        wait_drained();

        // radix below two saturates to binary, lower case
        write_reg(itra_pkg::CFG_RADIX, 8'h00);
        write_reg(itra_pkg::CFG_UPPER_CASE, 8'hfe);
        queue_value(32'h8000_0000);
        queue_value(-32'sd1);
        queue_value(-32'sd2);
        queue_value(32'h7fff_ffff);
        wait_drained();

        // radix above thirty-six saturates, sign form, spare index ignored
        write_reg(itra_pkg::CFG_RADIX, 8'h3f);
        write_reg(itra_pkg::CFG_COMPLEMENT, 8'h02);
        write_reg(CFG_SPARE, 8'hff);
        queue_value(32'd35);
        queue_value(-32'sd35);
        queue_value(32'h8000_0000);
        wait_drained();

        // random phases
        for (int ph = 0; ph < 8; ph++) begin
            calm = (ph == 3);
            rdata = itra_pkg::CFG_DATA_W'($urandom);
            if ($urandom_range(0, 9) == 0) begin
                rdata[itra_pkg::RADIX_W-1:0] = itra_pkg::RADIX_W'($urandom_range(0, 63));
            end else begin
                rdata[itra_pkg::RADIX_W-1:0] = itra_pkg::RADIX_W'($urandom_range(2, 36));
            end
            write_reg(itra_pkg::CFG_RADIX, rdata);
            write_reg(itra_pkg::CFG_UPPER_CASE, itra_pkg::CFG_DATA_W'($urandom));
            write_reg(itra_pkg::CFG_COMPLEMENT, itra_pkg::CFG_DATA_W'($urandom));
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                case ($urandom_range(0, 4))
                    0: v = $urandom;
                    1: v = $urandom >> $urandom_range(0, 31);
                    2: v = -($urandom >> $urandom_range(0, 31));
                    3: v = $urandom_range(0, 80) - 40;
                    default: v = ($urandom_range(0, 1) ? 32'h8000_0000 : 32'hffff_ffff)
                                 ^ $urandom_range(0, 15);
                endcase
                queue_value(v);
            end
            wait_drained();
        end

        if (errors == 0) begin
            $display("int_to_radix_ascii: match");
        end else begin
            $display("int_to_radix_ascii: mismatch");
        end
        $finish;
    end

endmodule
